// ===== sv/frame_time_domain_features_unit_assert.svh =====
// Assertion macros shared by the checker of the frame feature unit.
// Depends on nothing; expects signals named clk and arst_n in the using scope.
`ifndef FRAME_TIME_DOMAIN_FEATURES_UNIT_ASSERT_SVH
`define FRAME_TIME_DOMAIN_FEATURES_UNIT_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent
`define FTDF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its antecedent
`define FTDF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/ftdf_pkg.sv =====
// Package for the frame feature unit: widths, limits and shared types.
// Depends on nothing; all other files but the assertion header import it.
package ftdf_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int MAX_FRAME   = 4096;
	localparam int CNT_W       = 13;
	localparam int CROSS_W     = 12;
	localparam int SQ_W        = 2 * SAMPLE_W;
	localparam int SUM_W       = 43;
	localparam int ZCR_W       = 17;
	localparam int RMS_W       = 16;
	localparam int CREST_W     = 19;
	localparam int CREST_LIMIT = 262144;
	localparam int ZCR_SHIFT   = 16;
	localparam int CREST_SHIFT = 12;

	// Bit-serial divider: one quotient bit per cycle
	localparam int DIV_W      = 43;
	localparam int DIVS_W     = 16;
	localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

	// Bit-serial square root: one root bit (two radicand bits) per cycle
	localparam int RAD_W      = 2 * RMS_W;
	localparam int SQR_REM_W  = RMS_W + 2;
	localparam int SQR_CNT_W  = $clog2(RMS_W + 1);

	// Frame statistics handed from the accumulator to the sequencer
	typedef struct packed {
		logic [CROSS_W-1:0]  crossings;
		logic [CNT_W-1:0]    count;
		logic [SUM_W-1:0]    sum;
		logic [SAMPLE_W-1:0] peak;
		logic                overflow;
	} ftdf_stats_t;

endpackage

// ===== sv/ftdf_ifaces.sv =====
// Valid/ready channel interfaces of the frame feature unit.
// Depends on ftdf_pkg for the payload widths.
interface ftdf_sample_if import ftdf_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       frame_end;

	modport source (output valid, output sample, output frame_end, input ready);
	modport sink (input valid, input sample, input frame_end, output ready);
endinterface

interface ftdf_feat_if import ftdf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ZCR_W-1:0]   zcr_q16;
	logic [RMS_W-1:0]   rms_level;
	logic [CREST_W-1:0] crest_q12;
	logic [CNT_W-1:0]   frame_length;
	logic               frame_overflow;

	modport source (output valid, output zcr_q16, output rms_level, output crest_q12,
		output frame_length, output frame_overflow, input ready);
	modport sink (input valid, input zcr_q16, input rms_level, input crest_q12,
		input frame_length, input frame_overflow, output ready);
endinterface

// ===== sv/ftdf_accum.sv =====
// Per-sample accumulator: crossings, sample count, peak, sum of squares.
// Depends on ftdf_pkg.
module ftdf_accum import ftdf_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       take,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       clear,
	output ftdf_stats_t                stats
);

	logic                prev_nonneg_q;
	logic [CROSS_W-1:0]  cross_q;
	logic [CNT_W-1:0]    count_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] peak_q;
	logic                ovf_q;
	logic [SQ_W-1:0]     sq_s1;
	logic                sq_vld_s1;

	logic [SAMPLE_W-1:0] sample_u;
	logic [SAMPLE_W-1:0] mag;
	logic                nonneg;
	logic                room;

	// Magnitude and sign of the incoming sample
	assign sample_u = sample;
	assign nonneg   = ~sample_u[SAMPLE_W-1];
	assign mag      = sample_u[SAMPLE_W-1] ? (~sample_u + 1'b1) : sample_u;
	assign room     = count_q < CNT_W'(MAX_FRAME);

	// Count, crossings, peak; drop samples past the frame limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_nonneg_q <= 1'b0;
			cross_q       <= '0;
			count_q       <= '0;
			peak_q        <= '0;
			ovf_q         <= 1'b0;
			sq_vld_s1     <= 1'b0;
		end else if (clear) begin
			prev_nonneg_q <= 1'b0;
			cross_q       <= '0;
			count_q       <= '0;
			peak_q        <= '0;
			ovf_q         <= 1'b0;
			sq_vld_s1     <= 1'b0;
		end else begin
			sq_vld_s1 <= take && room;
			if (take) begin
				if (room) begin
					if (count_q != '0 && nonneg != prev_nonneg_q) begin
						cross_q <= cross_q + 1'b1;
					end
					prev_nonneg_q <= nonneg;
					if (mag > peak_q) begin
						peak_q <= mag;
					end
					count_q <= count_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	// Square in the accept cycle, add in the cycle after
	always_ff @(posedge clk) begin
		sq_s1 <= mag * mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (clear) begin
			sum_q <= '0;
		end else if (sq_vld_s1) begin
			sum_q <= sum_q + SUM_W'(sq_s1);
		end
	end

	assign stats.crossings = cross_q;
	assign stats.count     = count_q;
	assign stats.sum       = sum_q;
	assign stats.peak      = peak_q;
	assign stats.overflow  = ovf_q;

endmodule

// ===== sv/ftdf_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on ftdf_pkg. Divisor must be nonzero.
module ftdf_div import ftdf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_W-1:0]  dividend,
	input  logic [DIVS_W-1:0] divisor,
	output logic              done,
	output logic [DIV_W-1:0]  quotient
);

	logic [DIV_W-1:0]     quo_q;
	logic [DIVS_W-1:0]    rem_q;
	logic [DIVS_W-1:0]    dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIVS_W:0] trial;
	logic [DIVS_W:0] diff;
	logic            fits;

	// Shift in the next dividend bit and try a subtract
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== sv/ftdf_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on ftdf_pkg.
module ftdf_sqrt import ftdf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [RAD_W-1:0] radicand,
	output logic             done,
	output logic [RMS_W-1:0] root
);

	logic [RAD_W-1:0]     rad_q;
	logic [SQR_REM_W-1:0] rem_q;
	logic [RMS_W-1:0]     root_q;
	logic [SQR_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [SQR_REM_W+1:0] trial_rem;
	logic [SQR_REM_W+1:0] trial;
	logic [SQR_REM_W+1:0] diff;
	logic                 fits;

	// Bring down two radicand bits and test root*4+1
	assign trial_rem = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial     = {2'b00, root_q, 2'b01};
	assign diff      = trial_rem - trial;
	assign fits      = trial_rem >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= SQR_CNT_W'(RMS_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SQR_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= fits ? diff[SQR_REM_W-1:0] : trial_rem[SQR_REM_W-1:0];
			root_q <= {root_q[RMS_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== sv/frame_time_domain_features_unit.sv =====
// Frame time-domain features: zero-crossing rate, RMS level, crest factor.
// Channels: samples (sink) carries a signed Q1.15 sample and a frame_end flag;
// features (source) carries one result per frame. Both are valid/ready; a
// transaction completes on a clock edge with valid and ready high.
// During a frame one sample is taken every cycle. After the frame_end sample
// the unit stops taking samples while it finishes the frame: mean square by
// the bit-serial divider, root by the bit-serial square root, then the
// zero-crossing rate and crest factor by the same divider (the rate is
// skipped for a single-sample frame, the crest factor for a silent one).
// The result sits in an output register: while it waits for the receiver the
// next frame's samples are taken; only the end of that next frame waits for
// the register to empty.
// Samples past 4096 in a frame are dropped and flagged in frame_overflow.
// Reset (arst_n low) clears the frame statistics and drops a pending result.
// Depends on ftdf_pkg, ftdf_ifaces, ftdf_accum, ftdf_div and ftdf_sqrt.
module frame_time_domain_features_unit import ftdf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	ftdf_sample_if.sink  samples,
	ftdf_feat_if.source  features
);

	localparam logic [3:0] ST_ACC     = 4'd0;
	localparam logic [3:0] ST_DRAIN   = 4'd1;
	localparam logic [3:0] ST_MS_GO   = 4'd2;
	localparam logic [3:0] ST_MS_WAIT = 4'd3;
	localparam logic [3:0] ST_SQ_GO   = 4'd4;
	localparam logic [3:0] ST_SQ_WAIT = 4'd5;
	localparam logic [3:0] ST_ZC_GO   = 4'd6;
	localparam logic [3:0] ST_ZC_WAIT = 4'd7;
	localparam logic [3:0] ST_CR_GO   = 4'd8;
	localparam logic [3:0] ST_CR_WAIT = 4'd9;
	localparam logic [3:0] ST_DONE    = 4'd10;

	logic [3:0]         state_q;
	logic [3:0]         state_d;
	logic [ZCR_W-1:0]   zcr_q;
	logic [RMS_W-1:0]   rms_q;
	logic [CREST_W-1:0] crest_q;

	logic               out_valid_q;
	logic [ZCR_W-1:0]   out_zcr_q;
	logic [RMS_W-1:0]   out_rms_q;
	logic [CREST_W-1:0] out_crest_q;
	logic [CNT_W-1:0]   out_len_q;
	logic               out_ovf_q;

	ftdf_stats_t        stats;
	logic               in_take;
	logic               out_take;
	logic               load_out;
	logic               n_ge2;

	logic               div_start;
	logic [DIV_W-1:0]   div_dividend;
	logic [DIVS_W-1:0]  div_divisor;
	logic               div_done;
	logic [DIV_W-1:0]   div_quo;
	logic               sqrt_start;
	logic               sqrt_done;
	logic [RMS_W-1:0]   sqrt_root;

	assign samples.ready = (state_q == ST_ACC);
	assign in_take       = samples.valid && samples.ready;
	assign out_take      = out_valid_q && features.ready;
	assign load_out      = (state_q == ST_DONE) && (!out_valid_q || features.ready);
	assign n_ge2         = stats.count >= CNT_W'(2);

	ftdf_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (in_take),
		.sample (samples.sample),
		.clear  (load_out),
		.stats  (stats)
	);

	// Pick operands for the shared divider by phase
	always_comb begin
		div_start    = 1'b0;
		div_dividend = stats.sum;
		div_divisor  = DIVS_W'(stats.count);
		case (state_q)
			ST_MS_GO: begin
				div_start = 1'b1;
			end
			ST_ZC_GO: begin
				div_start    = 1'b1;
				div_dividend = DIV_W'({stats.crossings, ZCR_SHIFT'(0)});
				div_divisor  = DIVS_W'(stats.count) - 1'b1;
			end
			ST_CR_GO: begin
				div_start    = 1'b1;
				div_dividend = DIV_W'({stats.peak, CREST_SHIFT'(0)});
				div_divisor  = rms_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	assign sqrt_start = (state_q == ST_SQ_GO);

	ftdf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	ftdf_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (div_quo[RAD_W-1:0]),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// Sequence the end-of-frame computations
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_ACC:     if (in_take && samples.frame_end) state_d = ST_DRAIN;
			ST_DRAIN:   state_d = ST_MS_GO;
			ST_MS_GO:   state_d = ST_MS_WAIT;
			ST_MS_WAIT: if (div_done) state_d = ST_SQ_GO;
			ST_SQ_GO:   state_d = ST_SQ_WAIT;
			ST_SQ_WAIT: begin
				if (sqrt_done) begin
					if (n_ge2) begin
						state_d = ST_ZC_GO;
					end else if (sqrt_root != '0) begin
						state_d = ST_CR_GO;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_ZC_GO:   state_d = ST_ZC_WAIT;
			ST_ZC_WAIT: begin
				if (div_done) begin
					state_d = (rms_q != '0) ? ST_CR_GO : ST_DONE;
				end
			end
			ST_CR_GO:   state_d = ST_CR_WAIT;
			ST_CR_WAIT: if (div_done) state_d = ST_DONE;
			ST_DONE:    if (load_out) state_d = ST_ACC;
			default:    state_d = ST_ACC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
		end else begin
			state_q <= state_d;
		end
	end

	// Clear rate and crest on drain; capture each feature value as its unit finishes
	always_ff @(posedge clk) begin
		if (state_q == ST_DRAIN) begin
			zcr_q   <= '0;
			crest_q <= '0;
		end
		if (state_q == ST_SQ_WAIT && sqrt_done) begin
			rms_q <= sqrt_root;
		end
		if (state_q == ST_ZC_WAIT && div_done) begin
			zcr_q <= div_quo[ZCR_W-1:0];
		end
		if (state_q == ST_CR_WAIT && div_done) begin
			crest_q <= (div_quo > DIV_W'(CREST_LIMIT)) ? CREST_W'(CREST_LIMIT)
				: div_quo[CREST_W-1:0];
		end
	end

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_zcr_q   <= zcr_q;
			out_rms_q   <= rms_q;
			out_crest_q <= crest_q;
			out_len_q   <= stats.count;
			out_ovf_q   <= stats.overflow;
		end
	end

	assign features.valid          = out_valid_q;
	assign features.zcr_q16        = out_zcr_q;
	assign features.rms_level      = out_rms_q;
	assign features.crest_q12      = out_crest_q;
	assign features.frame_length   = out_len_q;
	assign features.frame_overflow = out_ovf_q;

endmodule

// ===== sv/ftdf_checker.sv =====
// Port-level checker for the frame feature unit, bound to the top level.
// Depends on ftdf_pkg and frame_time_domain_features_unit_assert.svh.
`include "frame_time_domain_features_unit_assert.svh"

module ftdf_checker import ftdf_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               in_frame_end,
	input logic               out_valid,
	input logic               out_ready,
	input logic [ZCR_W-1:0]   zcr_q16,
	input logic [RMS_W-1:0]   rms_level,
	input logic [CREST_W-1:0] crest_q12,
	input logic [CNT_W-1:0]   frame_length,
	input logic               frame_overflow
);

	// A pending result stays until its transaction completes
	`FTDF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result withdrawn before taken")

	// The frame_end transaction starts the end-of-frame work and closes the input
	`FTDF_ASSERT_NEXT(a_frame_busy, in_valid && in_ready && in_frame_end, !in_ready, "input open after frame end")

	// A truncated frame reports the full frame length
	`FTDF_ASSERT_SAME(a_ovf_len, out_valid && frame_overflow, frame_length == CNT_W'(MAX_FRAME), "overflow with short frame length")

	// A single-sample frame has no crossing rate
	`FTDF_ASSERT_SAME(a_zcr_short, out_valid && frame_length == CNT_W'(1), zcr_q16 == '0, "crossing rate on one-sample frame")

	// A silent frame has no crest factor
	`FTDF_ASSERT_SAME(a_crest_silent, out_valid && rms_level == '0, crest_q12 == '0, "crest factor on silent frame")

endmodule

bind frame_time_domain_features_unit ftdf_checker u_ftdf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (samples.valid),
	.in_ready       (samples.ready),
	.in_frame_end   (samples.frame_end),
	.out_valid      (features.valid),
	.out_ready      (features.ready),
	.zcr_q16        (features.zcr_q16),
	.rms_level      (features.rms_level),
	.crest_q12      (features.crest_q12),
	.frame_length   (features.frame_length),
	.frame_overflow (features.frame_overflow)
);

// ===== tb/frame_time_domain_features_unit_tb.sv =====
// Testbench for frame_time_domain_features_unit: frames of Q1.15 samples in, one feature
// record per frame out. A scoreboard predicts ZCR, RMS, crest and length per frame.
// Depends on ftdf_pkg, ftdf_ifaces and the RTL of the unit.
import ftdf_pkg::*;

typedef struct packed {
	logic [ZCR_W-1:0]   zcr_q16;
	logic [RMS_W-1:0]   rms_level;
	logic [CREST_W-1:0] crest_q12;
	logic [CNT_W-1:0]   frame_length;
	logic               frame_overflow;
} frame_features_t;

// Track the open frame's statistics and hold the feature records still to arrive
class frame_feature_scoreboard;
	frame_features_t expected_features[$];
	int unsigned mismatches;
	int unsigned results_seen;

	logic                prev_nonneg;
	logic [CROSS_W-1:0]  crossings;
	logic [CNT_W-1:0]    taken;
	logic [SUM_W-1:0]    energy;
	logic [SAMPLE_W-1:0] peak;
	logic                truncated;

	function new();
		mismatches = 0;
		results_seen = 0;
		clear_frame();
	endfunction

	function void clear_frame();
		prev_nonneg = 1'b0;
		crossings = '0;
		taken = '0;
		energy = '0;
		peak = '0;
		truncated = 1'b0;
	endfunction

	// Fold one accepted sample into the frame; predict the record on the last one
	function void note_sample(logic signed [SAMPLE_W-1:0] s, logic last);
		logic [SAMPLE_W-1:0] mag;
		longint unsigned n, wide, mean_sq, root, trial, crest;
		frame_features_t rec;
		mag = s[SAMPLE_W-1] ? -s : s;
		if (int'(taken) < MAX_FRAME) begin
			// zero counts as non-negative; the first sample only sets the sign
			if (taken != 0 && (!s[SAMPLE_W-1]) != prev_nonneg)
				crossings++;
			prev_nonneg = !s[SAMPLE_W-1];
			energy += SUM_W'(mag) * SUM_W'(mag);
			if (mag > peak)
				peak = mag;
			taken++;
		end else begin
			truncated = 1'b1;
		end
		if (!last)
			return;

		n = taken;
		rec = '0;
		wide = crossings;
		if (n >= 2)
			rec.zcr_q16 = ZCR_W'((wide << ZCR_SHIFT) / (n - 1));
		wide = energy;
		mean_sq = (n == 0) ? 0 : wide / n;
		// floor square root, one bit at a time from the top
		root = 0;
		for (int b = RMS_W; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= mean_sq)
				root = trial;
		end
		rec.rms_level = RMS_W'(root);
		if (root != 0) begin
			wide = peak;
			crest = (wide << CREST_SHIFT) / root;
			if (crest > CREST_LIMIT)
				crest = CREST_LIMIT;
			rec.crest_q12 = CREST_W'(crest);
		end
		rec.frame_length = taken;
		rec.frame_overflow = truncated;
		expected_features.push_back(rec);
		clear_frame();
	endfunction

	task report_mismatch(string what);
		mismatches++;
		if (mismatches <= 50)
			$display("mismatch: %s", what);
	endtask

	// Compare one received record with the oldest prediction
	task check_result(frame_features_t got);
		frame_features_t want;
		results_seen++;
		if (expected_features.size() == 0) begin
			report_mismatch($sformatf("record %0d arrived with none pending, length %0d",
				results_seen, got.frame_length));
			return;
		end
		want = expected_features.pop_front();
		if (got.zcr_q16 !== want.zcr_q16)
			report_mismatch($sformatf("record %0d zcr_q16 %0d, want %0d",
				results_seen, got.zcr_q16, want.zcr_q16));
		if (got.rms_level !== want.rms_level)
			report_mismatch($sformatf("record %0d rms_level %0d, want %0d",
				results_seen, got.rms_level, want.rms_level));
		if (got.crest_q12 !== want.crest_q12)
			report_mismatch($sformatf("record %0d crest_q12 %0d, want %0d",
				results_seen, got.crest_q12, want.crest_q12));
		if (got.frame_length !== want.frame_length)
			report_mismatch($sformatf("record %0d frame_length %0d, want %0d",
				results_seen, got.frame_length, want.frame_length));
		if (got.frame_overflow !== want.frame_overflow)
			report_mismatch($sformatf("record %0d frame_overflow %0b, want %0b",
				results_seen, got.frame_overflow, want.frame_overflow));
	endtask
endclass

module frame_time_domain_features_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_MAX          = 7;
	localparam int RANDOM_ITEMS      = 1950;
	localparam int MIN_RANDOM_FRAMES = 40;
	localparam int DRAIN_CYCLES      = 200;
	localparam int HOLD_CYCLES       = 600;

	logic clk;
	logic arst_n;
	int unsigned send_quiet = 0;
	int unsigned recv_quiet = 0;
	int unsigned items_sent = 0;

	ftdf_sample_if samples_if();
	ftdf_feat_if features_if();
	frame_feature_scoreboard sb = new();

	frame_time_domain_features_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_if),
		.features(features_if)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Draw an idle count; now and then start a stretch with no idling
	function automatic int draw_gap(inout int unsigned quiet_left);
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		if ($urandom_range(0, 63) == 0) begin
			quiet_left = $urandom_range(16, 96);
			return 0;
		end
		return $urandom_range(0, IDLE_MAX);
	endfunction

	// Offer one sample and hold it until the transaction completes
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic last);
		int gap;
		gap = draw_gap(send_quiet);
		if (gap > 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples_if.valid <= 1'b1;
		samples_if.sample <= s;
		samples_if.frame_end <= last;
		do @(posedge clk); while (!samples_if.ready);
		sb.note_sample(s, last);
		items_sent++;
	endtask

	task automatic send_frame(input logic signed [SAMPLE_W-1:0] frame[$]);
		foreach (frame[i])
			send_sample(frame[i], i == frame.size() - 1);
	endtask

	// Stimulus: directed frames, then random frames
	initial begin
		logic signed [SAMPLE_W-1:0] frame[$];
		int unsigned len, pick, style, frames_sent, random_start;
		int level;
		arst_n <= 1'b0;
		samples_if.valid <= 1'b0;
		samples_if.sample <= '0;
		samples_if.frame_end <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// single-sample frames: full-scale negative, then silence
		frame = '{16'sh8000};
		send_frame(frame);
		frame = '{16'sh0000};
		send_frame(frame);
		// alternating extremes: every step crosses
		frame = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000};
		send_frame(frame);
		// zero sits on the non-negative side
		frame = '{-16'sd5, 16'sd0, 16'sd0, -16'sd3};
		send_frame(frame);
		// mean square floors to zero
		frame = '{16'sd1, 16'sd0, 16'sd0};
		send_frame(frame);
		// bit patterns
		frame = '{16'sh5555, 16'shAAAA, 16'sh0001, 16'shFFFE};
		send_frame(frame);
		// over-long frame: one spike, then +/-1 crossing every sample; crest saturates,
		// the tail is dropped and frame_end lands on a dropped sample
		frame = '{16'sh7FFF};
		for (int i = 1; i < MAX_FRAME; i++)
			frame.push_back((i % 2) ? -16'sd1 : 16'sd1);
		frame.push_back(16'sh8000);
		frame.push_back(16'sh7FFF);
		frame.push_back(16'sh8000);
		send_frame(frame);
		// state must be clear after the truncated frame
		frame = '{16'sd100, -16'sd100};
		send_frame(frame);

		// random frames, mostly short
		frames_sent = 0;
		random_start = items_sent;
		while (items_sent - random_start < RANDOM_ITEMS || frames_sent < MIN_RANDOM_FRAMES) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				len = $urandom_range(1, 16);
			else if (pick < 95)
				len = $urandom_range(17, 100);
			else
				len = $urandom_range(101, 400);
			style = $urandom_range(0, 3);
			level = int'($urandom_range(0, 65533)) - 32767;
			frame.delete();
			repeat (len) begin
				case (style)
				0: begin
					frame.push_back(SAMPLE_W'($urandom));
				end
				1: begin
					frame.push_back(SAMPLE_W'(int'($urandom_range(0, 15)) - 8));
				end
				2: begin
					case ($urandom_range(0, 3))
					0: frame.push_back(16'sh8000);
					1: frame.push_back(16'sh7FFF);
					2: frame.push_back(16'sh0000);
					default: frame.push_back(-16'sd1);
					endcase
				end
				default: begin
					frame.push_back(SAMPLE_W'(level + int'($urandom_range(0, 2)) - 1));
				end
				endcase
			end
			send_frame(frame);
			frames_sent++;
		end
		samples_if.valid <= 1'b0;

		// drain, then allow for a stray late record
		while (sb.expected_features.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_features.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Receiver: random idling, and two long hold-offs that back the unit up
	initial begin
		frame_features_t got;
		int gap;
		features_if.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			gap = draw_gap(recv_quiet);
			if (sb.results_seen == 3 || sb.results_seen == 30)
				gap = HOLD_CYCLES;
			if (gap > 0) begin
				features_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			features_if.ready <= 1'b1;
			do @(posedge clk); while (!features_if.valid);
			got.zcr_q16 = features_if.zcr_q16;
			got.rms_level = features_if.rms_level;
			got.crest_q12 = features_if.crest_q12;
			got.frame_length = features_if.frame_length;
			got.frame_overflow = features_if.frame_overflow;
			sb.check_result(got);
		end
	end

	// Watchdog
	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+sv
sv/ftdf_pkg.sv
sv/ftdf_ifaces.sv
sv/ftdf_accum.sv
sv/ftdf_div.sv
sv/ftdf_sqrt.sv
sv/frame_time_domain_features_unit.sv
sv/ftdf_checker.sv
tb/frame_time_domain_features_unit_tb.sv
